@@ rtl/core/dbh_pkg.sv @@
// dbh_pkg: shared constants for the distance band quantizer.
// Field widths, register indexes, reset values and queue sizing.
// No dependencies.
package dbh_pkg;

   localparam int DIST_W      = 25;
   localparam int BAND_OUT_W  = 4;
   localparam int THR_W       = 32;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int RADIUS_W    = 16;
   localparam int MARGIN_W    = 16;
   localparam int PCT_W       = 7;
   localparam int CM_PER_M    = 100;
   localparam int Q_DEPTH     = 2;
   localparam int Q_PTR_W     = $clog2(Q_DEPTH);

   localparam logic [CSR_ADDR_W-1:0] REG_FENCE_RADIUS = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_MARGIN_MIN   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_MARGIN_PCT   = 2'd2;

   localparam logic [RADIUS_W-1:0] RADIUS_RST = 16'd100;
   localparam logic [MARGIN_W-1:0] MARGIN_RST = 16'd200;
   localparam logic [PCT_W-1:0]    PCT_RST    = 7'd10;

endpackage

@@ rtl/core/distance_band_with_hysteresis_top.sv @@
// Distance band quantizer with hysteresis: top level.
// A sample goes from the classifier through the queue into the result register, which drives the rsp_ ports.
// Throughput: one sample per cycle while the queue is not full and results are popped, set by
// the hysteresis compare on the last reported band; a 2-entry queue separates classifier and decision.
// Reset: synchronous, active high; registers return to 100 m / 200 cm / 10 %,
// reported band to 1, queue and result register empty.
module distance_band_with_hysteresis_top #(
   parameter int NUM_BANDS = 10
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic signed [dbh_pkg::DIST_W-1:0]    req_distance_cm,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic [dbh_pkg::BAND_OUT_W-1:0]       rsp_band,
   output logic [dbh_pkg::BAND_OUT_W-1:0]       rsp_raw_band,
   output logic                                 rsp_changed,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dbh_pkg::CSR_ADDR_W-1:0]       csr_index,
   input  logic [dbh_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import dbh_pkg::*;

   localparam int BAND_W = $clog2(NUM_BANDS + 1);
   localparam int ITEM_W = THR_W + BAND_W;

   logic signed [THR_W-1:0] band_edge [NUM_BANDS-1];
   logic signed [THR_W-1:0] up_thr    [NUM_BANDS];
   logic signed [THR_W-1:0] dn_thr    [NUM_BANDS];
   logic                    width_zero;

   logic                    q_push, q_full, q_pop, q_empty;
   logic signed [THR_W-1:0] f_scaled;
   logic [BAND_W-1:0]       f_raw;
   logic [ITEM_W-1:0]       q_wdata, q_rdata;
   logic signed [THR_W-1:0] b_scaled;
   logic [BAND_W-1:0]       b_raw;

   dbh_cfg #(.NUM_BANDS(NUM_BANDS)) u_cfg (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .band_edge  (band_edge),
      .up_thr     (up_thr),
      .dn_thr     (dn_thr),
      .width_zero (width_zero)
   );

   dbh_front #(.NUM_BANDS(NUM_BANDS)) u_front (
      .req_push        (req_push),
      .req_full        (req_full),
      .req_distance_cm (req_distance_cm),
      .band_edge       (band_edge),
      .width_zero      (width_zero),
      .q_full          (q_full),
      .q_push          (q_push),
      .scaled          (f_scaled),
      .raw_band        (f_raw)
   );

   assign q_wdata  = {f_scaled, f_raw};
   assign b_scaled = $signed(q_rdata[ITEM_W-1:BAND_W]);
   assign b_raw    = q_rdata[BAND_W-1:0];

   dbh_fifo #(.DATA_W(ITEM_W)) u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   dbh_back #(.NUM_BANDS(NUM_BANDS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_pop        (q_pop),
      .scaled       (b_scaled),
      .raw_band     (b_raw),
      .up_thr       (up_thr),
      .dn_thr       (dn_thr),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_band     (rsp_band),
      .rsp_raw_band (rsp_raw_band),
      .rsp_changed  (rsp_changed)
   );

endmodule

@@ rtl/core/dbh_cfg.sv @@
// dbh_cfg: configuration registers and the band edge / hysteresis thresholds
// derived from them, all scaled to cm * NUM_BANDS. Depends on dbh_pkg.
module dbh_cfg #(
   parameter int NUM_BANDS = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [dbh_pkg::CSR_ADDR_W-1:0]        csr_index,
   input  logic [dbh_pkg::CSR_DATA_W-1:0]        csr_wdata,
   output logic signed [dbh_pkg::THR_W-1:0]      band_edge [NUM_BANDS-1],
   output logic signed [dbh_pkg::THR_W-1:0]      up_thr    [NUM_BANDS],
   output logic signed [dbh_pkg::THR_W-1:0]      dn_thr    [NUM_BANDS],
   output logic                                  width_zero
);
   import dbh_pkg::*;

   logic [RADIUS_W-1:0] radius_ff, radius_in;
   logic [MARGIN_W-1:0] margin_min_ff, margin_min_in;
   logic [PCT_W-1:0]    pct_ff, pct_in;

   logic signed [THR_W-1:0] edge_ff [NUM_BANDS-1];
   logic signed [THR_W-1:0] edge_in [NUM_BANDS-1];
   logic signed [THR_W-1:0] up_ff   [NUM_BANDS];
   logic signed [THR_W-1:0] up_in   [NUM_BANDS];
   logic signed [THR_W-1:0] dn_ff   [NUM_BANDS];
   logic signed [THR_W-1:0] dn_in   [NUM_BANDS];
   logic                    wzero_ff, wzero_in;

   logic signed [THR_W-1:0] width_v, by_min, by_pct, margin_v;
   logic                    wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid & csr_ready;

   always_comb begin
      radius_in     = radius_ff;
      margin_min_in = margin_min_ff;
      pct_in        = pct_ff;
      if (reset) begin
         radius_in     = RADIUS_RST;
         margin_min_in = MARGIN_RST;
         pct_in        = PCT_RST;
      end else if (wr) begin
         unique case (csr_index)
            REG_FENCE_RADIUS: radius_in     = csr_wdata[RADIUS_W-1:0];
            REG_MARGIN_MIN:   margin_min_in = csr_wdata[MARGIN_W-1:0];
            REG_MARGIN_PCT:   pct_in        = csr_wdata[PCT_W-1:0];
            default: ;
         endcase
      end
   end

   // thresholds follow the new register values in the same edge
   always_comb begin
      width_v  = $signed(THR_W'(radius_in) * THR_W'(CM_PER_M));
      by_min   = $signed(THR_W'(margin_min_in) * THR_W'(NUM_BANDS));
      by_pct   = $signed(THR_W'(radius_in) * THR_W'(pct_in));
      margin_v = (by_min > by_pct) ? by_min : by_pct;
      wzero_in = (radius_in == '0);
      for (int i = 1; i < NUM_BANDS; i++) begin
         edge_in[i-1] = $signed(THR_W'(i) * width_v);
      end
      for (int b = 1; b <= NUM_BANDS; b++) begin
         up_in[b-1] = $signed(THR_W'(b) * width_v) + margin_v;
         dn_in[b-1] = $signed(THR_W'(b - 1) * width_v) - margin_v;
      end
   end

   always_ff @(posedge clock) begin
      radius_ff     <= radius_in;
      margin_min_ff <= margin_min_in;
      pct_ff        <= pct_in;
      wzero_ff      <= wzero_in;
      edge_ff       <= edge_in;
      up_ff         <= up_in;
      dn_ff         <= dn_in;
   end

   assign band_edge  = edge_ff;
   assign up_thr     = up_ff;
   assign dn_thr     = dn_ff;
   assign width_zero = wzero_ff;

endmodule

@@ rtl/core/dbh_front.sv @@
// dbh_front: input acceptance and raw band classification of one sample.
// Depends on dbh_pkg; edges come from dbh_cfg.
module dbh_front #(
   parameter int NUM_BANDS = 10
) (
   input  logic                                         req_push,
   output logic                                         req_full,
   input  logic signed [dbh_pkg::DIST_W-1:0]            req_distance_cm,
   input  logic signed [dbh_pkg::THR_W-1:0]             band_edge [NUM_BANDS-1],
   input  logic                                         width_zero,
   input  logic                                         q_full,
   output logic                                         q_push,
   output logic signed [dbh_pkg::THR_W-1:0]             scaled,
   output logic [$clog2(NUM_BANDS+1)-1:0]               raw_band
);
   import dbh_pkg::*;

   localparam int BAND_W = $clog2(NUM_BANDS + 1);

   logic signed [THR_W-1:0] dist_ext;

   assign req_full = q_full;
   assign q_push   = req_push & ~q_full;

   always_comb begin
      dist_ext = THR_W'(req_distance_cm);
      scaled   = dist_ext * $signed(THR_W'(NUM_BANDS));
      raw_band = BAND_W'(NUM_BANDS);
      for (int i = NUM_BANDS - 1; i >= 1; i--) begin
         if (scaled <= band_edge[i-1]) raw_band = BAND_W'(i);
      end
      if (scaled <= 0 || width_zero) raw_band = BAND_W'(1);
   end

endmodule

@@ rtl/core/dbh_fifo.sv @@
// dbh_fifo: short queue between classifier and hysteresis stage.
// Depth from dbh_pkg::Q_DEPTH.
module dbh_fifo #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] wdata,
   output logic              full,
   input  logic              pop,
   output logic [DATA_W-1:0] rdata,
   output logic              empty
);
   import dbh_pkg::*;

   logic [DATA_W-1:0]  mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [Q_PTR_W:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = (count_ff == (Q_PTR_W+1)'(Q_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? Q_PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? Q_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/core/dbh_back.sv @@
// dbh_back: hysteresis decision against the last reported band and the
// result register. Depends on dbh_pkg; thresholds come from dbh_cfg.
module dbh_back #(
   parameter int NUM_BANDS = 10
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   q_empty,
   output logic                                   q_pop,
   input  logic signed [dbh_pkg::THR_W-1:0]       scaled,
   input  logic [$clog2(NUM_BANDS+1)-1:0]         raw_band,
   input  logic signed [dbh_pkg::THR_W-1:0]       up_thr [NUM_BANDS],
   input  logic signed [dbh_pkg::THR_W-1:0]       dn_thr [NUM_BANDS],
   output logic                                   rsp_empty,
   input  logic                                   rsp_pop,
   output logic [dbh_pkg::BAND_OUT_W-1:0]         rsp_band,
   output logic [dbh_pkg::BAND_OUT_W-1:0]         rsp_raw_band,
   output logic                                   rsp_changed
);
   import dbh_pkg::*;

   localparam int BAND_W = $clog2(NUM_BANDS + 1);
   localparam int IDX_W  = $clog2(NUM_BANDS);

   logic [BAND_W-1:0] cur_ff, cur_in;
   logic              valid_ff, valid_in;
   logic [BAND_W-1:0] band_ff, raw_ff;
   logic              changed_ff;
   logic [BAND_W-1:0] prev_m1, next_band;
   logic [IDX_W-1:0]  idx;

   assign q_pop   = ~q_empty & (~valid_ff | rsp_pop);
   assign prev_m1 = BAND_W'(cur_ff - 1'b1);
   assign idx     = prev_m1[IDX_W-1:0];

   always_comb begin
      next_band = raw_band;
      if (raw_band > cur_ff) begin
         if (scaled < up_thr[idx]) next_band = cur_ff;
      end else if (raw_band < cur_ff) begin
         if (scaled > dn_thr[idx]) next_band = cur_ff;
      end
      cur_in   = q_pop ? next_band : cur_ff;
      valid_in = q_pop | (valid_ff & ~rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff   <= BAND_W'(1);
         valid_ff <= 1'b0;
      end else begin
         cur_ff   <= cur_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         band_ff    <= next_band;
         raw_ff     <= raw_band;
         changed_ff <= (next_band != cur_ff);
      end
   end

   assign rsp_empty    = ~valid_ff;
   assign rsp_band     = BAND_OUT_W'(band_ff);
   assign rsp_raw_band = BAND_OUT_W'(raw_ff);
   assign rsp_changed  = changed_ff;

endmodule

@@ rtl/core/dbh_checker.sv @@
// dbh_checker: port-level assertions for the distance band quantizer,
// bound to distance_band_with_hysteresis_top. Depends on dbh_pkg.
module dbh_checker #(
   parameter int NUM_BANDS = 10
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_push,
   input logic                           req_full,
   input logic                           rsp_empty,
   input logic                           rsp_pop,
   input logic [dbh_pkg::BAND_OUT_W-1:0] rsp_band,
   input logic [dbh_pkg::BAND_OUT_W-1:0] rsp_raw_band,
   input logic                           rsp_changed
);
   import dbh_pkg::*;

   // a band change always lands on the raw band of that sample
   a_change_to_raw: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_changed) |-> (rsp_band == rsp_raw_band))
      else $error("band changed to a value other than raw band");

   a_band_nonzero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_band != '0 || NUM_BANDS >= 16))
      else $error("reported band is zero");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result pending right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_band)
                                    && $stable(rsp_changed)))
      else $error("waiting result not held");

endmodule

bind distance_band_with_hysteresis_top dbh_checker #(.NUM_BANDS(NUM_BANDS)) u_dbh_checker (.*);
